/* rtl/core/drc_pkg.sv */
`timescale 1ns / 1ps
package drc_pkg;
   localparam int VecSize  = 10;
   localparam int FracBits = 16;
   localparam int NPairs   = (VecSize * (VecSize + 1)) / 2;
   localparam int IdxW     = 4;
   localparam int PairW    = 6;
   localparam int ShiftIn  = 32 - FracBits;

   localparam logic [1:0] REG_SKIP = 2'd0;
   localparam logic [1:0] REG_DEC  = 2'd1;

   // signed 64 saturated add / sub
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else sat_add = s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) sat_sub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else sat_sub = s[63:0];
   endfunction
endpackage

/* rtl/core/drc_ram.sv */
`timescale 1ns / 1ps
module drc_ram #(
   parameter int Width = 64,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

/* rtl/core/drc_muldiv.sv */
`timescale 1ns / 1ps
// trunc(a*b/d) toward zero, saturated to signed 64. Multiply in four 32x32
// partial products, then restoring division, one bit a cycle.
module drc_muldiv
   import drc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] op_a,
   input  logic signed [63:0] op_b,
   input  logic [63:0]        op_d,
   output logic               done,
   output logic signed [63:0] result
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_DIV  = 3'b100
   } st_type;

   st_type             st_ff, st_in;
   logic [63:0]        ma_ff, mb_ff, d_ff;
   logic               neg_ff;
   logic [127:0]       prod_ff;
   logic [1:0]         pp_ff;
   logic [6:0]         bit_ff;
   logic [63:0]        rem_ff;
   logic [127:0]       q_ff;
   logic               done_ff;
   logic signed [63:0] res_ff;

   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [64:0]  rem_sh;
   logic         take;
   logic [127:0] q_next;
   logic [63:0]  lim;

   always_comb begin
      pa = pp_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
      pb = pp_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
      pp = {32'd0, pa} * {32'd0, pb};
      pp_sh = {64'd0, pp} << (7'(pp_ff[0]) * 7'd32 + 7'(pp_ff[1]) * 7'd32);
      rem_sh = {rem_ff, prod_ff[bit_ff]};
      take = rem_sh >= {1'b0, d_ff};
      q_next = q_ff;
      q_next[bit_ff] = take;
      lim = neg_ff ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (start) st_in = S_MUL;
         S_MUL:  if (pp_ff == 2'd3) st_in = S_DIV;
         S_DIV:  if (bit_ff == 7'd0) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= (st_ff == S_DIV) && (bit_ff == 7'd0);
      end
      unique case (st_ff)
         S_IDLE: begin
            ma_ff   <= op_a[63] ? 64'd0 - op_a : op_a;
            mb_ff   <= op_b[63] ? 64'd0 - op_b : op_b;
            d_ff    <= (op_d == 64'd0) ? 64'd1 : op_d;
            neg_ff  <= op_a[63] != op_b[63];
            prod_ff <= '0;
            pp_ff   <= 2'd0;
         end
         S_MUL: begin
            prod_ff <= prod_ff + pp_sh;
            pp_ff   <= pp_ff + 2'd1;
            bit_ff  <= 7'd127;
            rem_ff  <= '0;
            q_ff    <= '0;
         end
         S_DIV: begin
            rem_ff <= take ? 64'(rem_sh - {1'b0, d_ff}) : rem_sh[63:0];
            q_ff   <= q_next;
            bit_ff <= bit_ff - 7'd1;
            if (bit_ff == 7'd0) begin
               if (q_next[127:64] != 64'd0 || q_next[63:0] > lim)
                  res_ff <= neg_ff ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
               else if (neg_ff) res_ff <= 64'd0 - q_next[63:0];
               else res_ff <= q_next[63:0];
            end
         end
         default: ;
      endcase
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

/* rtl/core/decimated_running_covariance.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | energy, strain_11..33, flush
// rsp     | out       | rsp_valid/rsp_ready  | row/col index, mean, covariance, count, last
// csr     | in        | psel/penable/pready  | skip_records, decimation
// A flush or a vector still inside skip_records is taken without a multiply-divide.
// Any other vector runs one multiply-divide (post-skip count by decimation).
// A kept vector then updates the 10 means and the 55 covariances; after the first
// kept vector each step is two passes through the single shared multiply-divide unit
// (partial products, then restoring division) plus ram reads; the first only writes.
// A flush steps through S_FRD and S_FOUT for each entry; rsp_ready stalls hold it in S_FRD.
// Synchronous reset clears counters and control; the stores are written first.
module decimated_running_covariance
   import drc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_energy,
   input  logic signed [31:0] req_strain_11,
   input  logic signed [31:0] req_strain_12,
   input  logic signed [31:0] req_strain_13,
   input  logic signed [31:0] req_strain_21,
   input  logic signed [31:0] req_strain_22,
   input  logic signed [31:0] req_strain_23,
   input  logic signed [31:0] req_strain_31,
   input  logic signed [31:0] req_strain_32,
   input  logic signed [31:0] req_strain_33,
   input  logic               req_flush,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_row_index,
   output logic [3:0]         rsp_col_index,
   output logic signed [63:0] rsp_row_mean,
   output logic signed [63:0] rsp_covariance,
   output logic [31:0]        rsp_kept_count,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_MRD   = 12'b000000000010,
      S_MA    = 12'b000000000100,
      S_MB    = 12'b000000001000,
      S_MWR   = 12'b000000010000,
      S_CRD   = 12'b000000100000,
      S_CA    = 12'b000001000000,
      S_CB    = 12'b000010000000,
      S_CWR   = 12'b000100000000,
      S_FRD   = 12'b001000000000,
      S_FOUT  = 12'b010000000000,
      S_KEEP  = 12'b100000000000
   } st_type;

   st_type st_ff;
   logic [19:0] skip_ff;
   logic [15:0] dec_ff;
   logic [31:0] seen_ff, post_ff, kept_ff;
   logic signed [63:0] x_ff [VecSize];
   logic [IdxW-1:0] j_ff, k_ff;
   logic [PairW-1:0] p_ff;
   logic signed [63:0] t1_ff, d1_ff;
   logic first_ff;

   // means: new and old in one word pair via two rams
   logic m_we, o_we, c_we;
   logic [IdxW-1:0] m_wa, m_ra, o_ra;
   logic [63:0] m_wd, o_wd, m_rd, o_rd, c_wd, c_rd;
   logic [PairW-1:0] c_wa, c_ra;

   drc_ram #(.Width(64), .Depth(16)) u_mean (
      .clock, .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));
   drc_ram #(.Width(64), .Depth(16)) u_old (
      .clock, .wr_en(o_we), .wr_addr(m_wa), .wr_data(o_wd),
      .rd_addr(o_ra), .rd_data(o_rd));
   drc_ram #(.Width(64), .Depth(64)) u_cov (
      .clock, .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
      .rd_addr(c_ra), .rd_data(c_rd));

   logic md_start, md_done;
   logic signed [63:0] md_a, md_b, md_r;
   logic [63:0] md_d;
   drc_muldiv u_md (.clock, .reset, .start(md_start), .op_a(md_a), .op_b(md_b),
                    .op_d(md_d), .done(md_done), .result(md_r));

   logic rsp_v_ff, last_ff;
   logic [3:0] ri_ff, ci_ff;
   logic signed [63:0] mo_ff, co_ff;
   logic [31:0] ko_ff;

   logic wr_cfg, accept, keep, skipping;
   logic [15:0] dec_eff;
   logic signed [63:0] xin [VecSize];
   logic signed [63:0] d2;

   assign pready = 1'b1;
   assign wr_cfg = psel && penable && pwrite;
   always_comb begin
      prdata = 32'd0;
      unique case (paddr[2])
         REG_SKIP[0]: prdata = {12'd0, skip_ff};
         REG_DEC[0]:  prdata = {16'd0, dec_ff};
         default:     prdata = 32'd0;
      endcase
   end

   assign req_ready = (st_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign skipping = seen_ff < {12'd0, skip_ff};
   assign dec_eff = (dec_ff == 16'd0) ? 16'd1 : dec_ff;
   // keep when quotient times decimation gives back the post-skip count
   assign keep = (32'(md_r[31:0] * {16'd0, dec_eff}) == post_ff);

   always_comb begin
      xin[0] = 64'(signed'(req_energy)) <<< ShiftIn;
      xin[1] = 64'(signed'(req_strain_11)) <<< ShiftIn;
      xin[2] = 64'(signed'(req_strain_12)) <<< ShiftIn;
      xin[3] = 64'(signed'(req_strain_13)) <<< ShiftIn;
      xin[4] = 64'(signed'(req_strain_21)) <<< ShiftIn;
      xin[5] = 64'(signed'(req_strain_22)) <<< ShiftIn;
      xin[6] = 64'(signed'(req_strain_23)) <<< ShiftIn;
      xin[7] = 64'(signed'(req_strain_31)) <<< ShiftIn;
      xin[8] = 64'(signed'(req_strain_32)) <<< ShiftIn;
      xin[9] = 64'(signed'(req_strain_33)) <<< ShiftIn;
   end

   assign d2 = sat_sub(x_ff[k_ff], o_rd);

   always_comb begin
      m_we = 1'b0; o_we = 1'b0; c_we = 1'b0;
      m_wa = j_ff; m_wd = md_r; o_wd = m_rd;
      m_ra = j_ff; o_ra = k_ff; c_ra = p_ff; c_wa = p_ff;
      c_wd = sat_add(t1_ff, md_r);
      md_start = 1'b0; md_a = '0; md_b = '0; md_d = '0;
      unique case (st_ff)
         S_IDLE: begin
            md_start = accept && !req_flush && !skipping;
            md_a = {32'd0, post_ff}; md_b = 64'sd1;
            md_d = {48'd0, dec_eff};
         end
         S_KEEP: ;
         S_MRD: begin
            if (first_ff) begin
               m_we = 1'b1; o_we = 1'b1; m_wd = x_ff[j_ff]; o_wd = x_ff[j_ff];
            end
         end
         S_MA: begin
            md_start = 1'b1; md_a = x_ff[j_ff]; md_b = 64'sd1;
            md_d = {32'd0, kept_ff} + 64'd1;
         end
         S_MB: begin
            md_start = md_done; md_a = m_rd; md_b = {32'd0, kept_ff};
            md_d = {32'd0, kept_ff} + 64'd1;
         end
         S_MWR: begin
            if (md_done) begin
               m_we = 1'b1; o_we = 1'b1; m_wd = sat_add(t1_ff, md_r);
            end
         end
         S_CRD: begin
            m_ra = j_ff;
            if (first_ff) begin
               c_we = 1'b1; c_wd = '0;
            end
         end
         S_CA: begin
            // the row difference is formed here on the diagonal entry
            md_start = 1'b1;
            md_a = (k_ff == j_ff) ? sat_sub(x_ff[j_ff], m_rd) : d1_ff;
            md_b = d2;
            md_d = {kept_ff, 32'd0};
         end
         S_CB: begin
            md_start = md_done; md_a = c_rd; md_b = {32'd0, kept_ff} - 64'd1;
            md_d = {32'd0, kept_ff};
         end
         S_CWR: c_we = md_done;
         S_FRD: ;
         S_FOUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         skip_ff  <= '0;
         dec_ff   <= 16'd1;
         seen_ff  <= '0;
         post_ff  <= '0;
         kept_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (wr_cfg) begin
            if (paddr[2] == REG_SKIP[0]) skip_ff <= pwdata[19:0];
            else dec_ff <= pwdata[15:0];
         end
         if (rsp_v_ff && rsp_ready) rsp_v_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (accept) begin
               j_ff <= '0; k_ff <= '0; p_ff <= '0;
               if (req_flush) st_ff <= S_FRD;
               else if (skipping) seen_ff <= seen_ff + 32'd1;
               else begin
                  if (seen_ff != 32'hFFFFFFFF) seen_ff <= seen_ff + 32'd1;
                  for (int i = 0; i < VecSize; i++) x_ff[i] <= xin[i];
                  st_ff <= S_KEEP;
               end
            end
            S_KEEP: if (md_done) begin
               post_ff <= post_ff + 32'd1;
               if (keep) begin
                  first_ff <= (kept_ff == 32'd0);
                  st_ff <= S_MRD;
               end else st_ff <= S_IDLE;
            end
            S_MRD: begin
               if (first_ff) begin
                  if (j_ff == IdxW'(VecSize - 1)) begin
                     j_ff <= '0; st_ff <= S_CRD;
                  end else j_ff <= j_ff + 1'b1;
               end else st_ff <= S_MA;
            end
            S_MA: st_ff <= S_MB;
            S_MB: if (md_done) begin t1_ff <= md_r; st_ff <= S_MWR; end
            S_MWR: if (md_done) begin
               if (j_ff == IdxW'(VecSize - 1)) begin
                  j_ff <= '0; k_ff <= '0; st_ff <= S_CRD;
               end else begin
                  j_ff <= j_ff + 1'b1; st_ff <= S_MRD;
               end
            end
            S_CRD: begin
               if (first_ff) begin
                  if (p_ff == PairW'(NPairs - 1)) begin
                     kept_ff <= kept_ff + 32'd1; st_ff <= S_IDLE;
                  end else p_ff <= p_ff + 1'b1;
               end else st_ff <= S_CA;
            end
            S_CA: if (k_ff == j_ff) d1_ff <= sat_sub(x_ff[j_ff], m_rd);
            default: ;
         endcase
         if (st_ff == S_CA) st_ff <= S_CB;
         if (st_ff == S_CB && md_done) begin t1_ff <= md_r; st_ff <= S_CWR; end
         if (st_ff == S_CWR && md_done) begin
            p_ff <= p_ff + 1'b1;
            if (k_ff == IdxW'(VecSize - 1)) begin
               if (j_ff == IdxW'(VecSize - 1)) begin
                  if (kept_ff != 32'hFFFFFFFF) kept_ff <= kept_ff + 32'd1;
                  st_ff <= S_IDLE;
               end else begin
                  j_ff <= j_ff + 1'b1; k_ff <= j_ff + 1'b1; st_ff <= S_CRD;
               end
            end else begin
               k_ff <= k_ff + 1'b1; st_ff <= S_CRD;
            end
         end
         if (st_ff == S_FRD && !rsp_v_ff) st_ff <= S_FOUT;
         if (st_ff == S_FOUT) begin
            rsp_v_ff <= 1'b1;
            ri_ff <= j_ff; ci_ff <= k_ff;
            mo_ff <= (kept_ff != 0) ? m_rd : 64'd0;
            co_ff <= (kept_ff != 0) ? c_rd : 64'd0;
            ko_ff <= kept_ff;
            last_ff <= (p_ff == PairW'(NPairs - 1));
            p_ff <= p_ff + 1'b1;
            if (p_ff == PairW'(NPairs - 1)) st_ff <= S_IDLE;
            else begin
               st_ff <= S_FRD;
               if (k_ff == IdxW'(VecSize - 1)) begin
                  j_ff <= j_ff + 1'b1; k_ff <= j_ff + 1'b1;
               end else k_ff <= k_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid      = rsp_v_ff;
   assign rsp_row_index  = ri_ff;
   assign rsp_col_index  = ci_ff;
   assign rsp_row_mean   = mo_ff;
   assign rsp_covariance = co_ff;
   assign rsp_kept_count = ko_ff;
   assign rsp_last       = last_ff;
endmodule

/* bench/decimated_running_covariance_tb.sv */
`timescale 1ns / 1ps
module decimated_running_covariance_tb;
   import drc_pkg::*;

   typedef struct {
      logic signed [31:0] elem [VecSize];
      logic               flush;
   } sample_item_type;

   typedef struct {
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [63:0] mean;
      logic signed [63:0] cov;
      logic [31:0]        count;
      logic               last;
   } cov_entry_type;

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_elem [VecSize];
   logic req_flush = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_row_index, rsp_col_index;
   logic signed [63:0] rsp_row_mean, rsp_covariance;
   logic [31:0] rsp_kept_count;
   logic rsp_last;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   sample_item_type pending_items [$];
   cov_entry_type   expected_entries [$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int mismatches = 0;
   bit took = 1'b0;

   // predictor state
   logic [19:0] skip_cfg = '0;
   logic [15:0] dec_cfg = 16'd1;
   logic [31:0] seen_cnt = '0, post_cnt = '0, kept_cnt = '0;
   logic signed [63:0] mean_q [VecSize];
   logic signed [63:0] prev_mean_q [VecSize];
   logic signed [63:0] cov_q [NPairs];

   initial for (int i = 0; i < VecSize; i++) req_elem[i] = '0;

   decimated_running_covariance dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_energy(req_elem[0]), .req_strain_11(req_elem[1]), .req_strain_12(req_elem[2]),
      .req_strain_13(req_elem[3]), .req_strain_21(req_elem[4]),
      .req_strain_22(req_elem[5]), .req_strain_23(req_elem[6]),
      .req_strain_31(req_elem[7]), .req_strain_32(req_elem[8]),
      .req_strain_33(req_elem[9]), .req_flush,
      .rsp_valid, .rsp_ready, .rsp_row_index, .rsp_col_index, .rsp_row_mean,
      .rsp_covariance, .rsp_kept_count, .rsp_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic signed [63:0] add_clip(logic signed [63:0] a,
                                                   logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(S64_MAX)) return S64_MAX;
      if (s < 65'(S64_MIN)) return S64_MIN;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sub_clip(logic signed [63:0] a,
                                                   logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s > 65'(S64_MAX)) return S64_MAX;
      if (s < 65'(S64_MIN)) return S64_MIN;
      return s[63:0];
   endfunction

   // trunc(a * b / d) toward zero, clipped to signed 64 bits
   function automatic logic signed [63:0] mul_div_clip(logic signed [63:0] a,
                                                       logic signed [63:0] b,
                                                       logic [63:0] d);
      logic neg;
      logic [63:0] ma, mb;
      logic [127:0] q;
      neg = a[63] != b[63];
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
      if (d == 0) d = 1;
      q = ({64'd0, ma} * {64'd0, mb}) / {64'd0, d};
      if (neg) begin
         if (q > 128'h8000_0000_0000_0000) return S64_MIN;
         return -$signed(q[63:0]);
      end
      if (q > 128'h7fff_ffff_ffff_ffff) return S64_MAX;
      return $signed(q[63:0]);
   endfunction

   task automatic absorb_vector(input sample_item_type it);
      logic signed [63:0] x [VecSize];
      logic signed [63:0] c, d1, d2;
      int p;
      c = {32'd0, kept_cnt};
      p = 0;
      for (int j = 0; j < VecSize; j++) x[j] = 64'(it.elem[j]) <<< ShiftIn;
      if (kept_cnt == 0) begin
         for (int j = 0; j < VecSize; j++) begin
            mean_q[j] = x[j];
            prev_mean_q[j] = x[j];
         end
         for (int i = 0; i < NPairs; i++) cov_q[i] = '0;
      end else begin
         for (int j = 0; j < VecSize; j++) begin
            prev_mean_q[j] = mean_q[j];
            mean_q[j] = add_clip(mul_div_clip(x[j], 64'sd1, c + 1),
                                 mul_div_clip(mean_q[j], c, c + 1));
         end
         for (int j = 0; j < VecSize; j++) begin
            d1 = sub_clip(x[j], mean_q[j]);
            for (int k = j; k < VecSize; k++) begin
               d2 = sub_clip(x[k], prev_mean_q[k]);
               cov_q[p] = add_clip(mul_div_clip(d1, d2, c << 32),
                                   mul_div_clip(cov_q[p], c - 1, c));
               p++;
            end
         end
      end
      if (kept_cnt != 32'hffff_ffff) kept_cnt++;
   endtask

   task automatic predict_item(input sample_item_type it);
      cov_entry_type e;
      int p;
      logic [15:0] dec;
      logic keep;
      p = 0;
      if (it.flush) begin
         for (int j = 0; j < VecSize; j++) begin
            for (int k = j; k < VecSize; k++) begin
               e.row = 4'(j);
               e.col = 4'(k);
               e.mean = kept_cnt != 0 ? mean_q[j] : '0;
               e.cov = kept_cnt != 0 ? cov_q[p] : '0;
               e.count = kept_cnt;
               e.last = p == NPairs - 1;
               expected_entries.push_back(e);
               p++;
            end
         end
      end else if (seen_cnt < {12'd0, skip_cfg}) begin
         seen_cnt++;
      end else begin
         if (seen_cnt != 32'hffff_ffff) seen_cnt++;
         dec = dec_cfg == 0 ? 16'd1 : dec_cfg;
         keep = (post_cnt % {16'd0, dec}) == 0;
         post_cnt++;
         if (keep) absorb_vector(it);
      end
   endtask

   // driver
   always @(negedge clock) begin
      sample_item_type it;
      if (!reset && (!req_valid || took)) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            for (int i = 0; i < VecSize; i++) req_elem[i] <= it.elem[i];
            req_flush <= it.flush;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      took = 1'b0;
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      sample_item_type it;
      cov_entry_type e;
      if (!reset && req_valid && req_ready) begin
         took = 1'b1;
         for (int i = 0; i < VecSize; i++) it.elem[i] = req_elem[i];
         it.flush = req_flush;
         predict_item(it);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_entries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected entry row %0d col %0d", rsp_row_index, rsp_col_index);
         end else begin
            e = expected_entries.pop_front();
            if (rsp_row_index !== e.row || rsp_col_index !== e.col ||
                rsp_row_mean !== e.mean || rsp_covariance !== e.cov ||
                rsp_kept_count !== e.count || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch exp r%0d c%0d m%h v%h n%0d l%b",
                            " got r%0d c%0d m%h v%h n%0d l%b"},
                           e.row, e.col, e.mean, e.cov, e.count, e.last,
                           rsp_row_index, rsp_col_index, rsp_row_mean, rsp_covariance,
                           rsp_kept_count, rsp_last);
            end
         end
      end
   end

   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2, 3: return $urandom_range(1) ? 32'($urandom_range(1 << 20))
                                        : -32'($urandom_range(1 << 20));
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(input logic signed [31:0] v, input bit flush, input bit rnd);
      sample_item_type it;
      for (int i = 0; i < VecSize; i++) it.elem[i] = rnd ? pick_sample() : v;
      it.flush = flush;
      pending_items.push_back(it);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx[0], 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_SKIP) skip_cfg = value[19:0];
      else dec_cfg = value[15:0];
   endtask

   // drain: each batch ends on a flush, so its last entry means the block is idle
   task automatic drain();
      wait (pending_items.size() == 0 && !req_valid && expected_entries.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_batch(input int n);
      for (int i = 0; i < n; i++) queue_item('0, $urandom_range(11) == 0, 1'b1);
      queue_item('0, 1'b1, 1'b1);
   endtask

   initial begin
      sample_item_type it;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 7;
      recv_idle_pct = 60;
      csr_write(REG_SKIP, 32'd0);
      csr_write(REG_DEC, 32'd1);
      // flush with no statistics, then extreme vectors
      queue_item('0, 1'b1, 1'b0);
      queue_item(32'sh7fff_ffff, 1'b0, 1'b0);
      queue_item(32'sh8000_0000, 1'b0, 1'b0);
      queue_item('0, 1'b0, 1'b0);
      for (int i = 0; i < VecSize; i++) it.elem[i] = i[0] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      it.flush = 1'b0;
      pending_items.push_back(it);
      queue_item('0, 1'b1, 1'b1);
      drain();
      // skip two more, then keep every second one
      csr_write(REG_SKIP, 32'd6);
      csr_write(REG_DEC, 32'd2);
      for (int i = 0; i < 6; i++) queue_item('0, 1'b0, 1'b1);
      queue_item('0, 1'b1, 1'b1);
      drain();
      // register extremes: everything dropped, then decimation zero
      csr_write(REG_SKIP, 32'hfffff);
      csr_write(REG_DEC, 32'hffff);
      for (int i = 0; i < 6; i++) queue_item('0, 1'b0, 1'b1);
      queue_item('0, 1'b1, 1'b1);
      drain();
      csr_write(REG_SKIP, 32'd0);
      csr_write(REG_DEC, 32'd0);
      for (int i = 0; i < 3; i++) queue_item('0, 1'b0, 1'b1);
      queue_item('0, 1'b1, 1'b1);
      drain();

      csr_write(REG_SKIP, 32'd40);
      csr_write(REG_DEC, 32'd13);
      random_batch(140);
      drain();
      send_idle_pct = 60;
      recv_idle_pct = 7;
      csr_write(REG_SKIP, 32'd0);
      csr_write(REG_DEC, 32'd17);
      random_batch(140);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_DEC, 32'd16);
      random_batch(140);
      drain();
      repeat (200) @(negedge clock);
      if (mismatches == 0 && expected_entries.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

/* decimated_running_covariance.f */
rtl/core/drc_pkg.sv
rtl/core/drc_ram.sv
rtl/core/drc_muldiv.sv
rtl/core/decimated_running_covariance.sv
bench/decimated_running_covariance_tb.sv
